// File: rtl/mbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types and constants of the per-user mailbox queue unit.
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int MAX_USERS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int LIMIT_CAP        = 16;
  localparam int LIM_W            = 9;
  localparam logic [15:0] NO_SENDER = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_REMOVE    = 4'd1,
    OP_POST_PRIV = 4'd2,
    OP_POST_PUB  = 4'd3,
    OP_READ_PRIV = 4'd4,
    OP_READ_PUB  = 4'd5,
    OP_SET_LIMIT = 4'd6,
    OP_CLEAR     = 4'd7,
    OP_QUERY     = 4'd8,
    OP_TOTALS    = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_NOUSER  = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_FULL    = 3'd4,
    ST_STOPPED = 3'd5,
    ST_EMPTY   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    C_NONE, C_ADD, C_REMOVE, C_PPUSH, C_PDROP, C_QPUSH, C_QDROP,
    C_PPOP, C_QPOP, C_TRIM, C_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] user;
    logic [14:0] sender;
    logic [LIM_W-1:0] limit;
  } mbq_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WALK, S_READ, S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/mbq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_if
// Request, response and configuration channels of the mailbox unit.
// ----------------------------------------------------------------------------
interface mbq_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [15:0] user_id;
  logic [15:0] caller_id;
  logic [14:0] sender_id;
  logic [63:0] message_word;
  logic [7:0]  new_limit;
  modport source (output valid, operation, user_id, caller_id, sender_id,
                  message_word, new_limit, input ready);
  modport sink (input valid, operation, user_id, caller_id, sender_id,
                message_word, new_limit, output ready);
endinterface

interface mbq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] message_out;
  logic        message_valid;
  logic [4:0]  private_fill;
  logic [31:0] drops;
  logic signed [15:0] last_sender;
  logic [4:0]  limit_now;
  logic [3:0]  users_now;
  logic [7:0]  private_total;
  modport source (output valid, status, message_out, message_valid, private_fill,
                  drops, last_sender, limit_now, users_now, private_total,
                  input ready);
  modport sink (input valid, status, message_out, message_valid, private_fill,
                drops, last_sender, limit_now, users_now, private_total,
                output ready);
endinterface

interface mbq_cfg_if;
  logic valid;
  logic ready;
  logic enabled;
  modport source (output valid, enabled, input ready);
  modport sink (input valid, enabled, output ready);
endinterface
`default_nettype wire

// File: rtl/mbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/mbq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_cell
// One user slot: id, queue counts and heads, drop counter, last sender.
// ----------------------------------------------------------------------------
module mbq_cell import mbq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  mbq_cmd_t      cmd,
  input  logic          sel,
  input  logic          free_in,
  output logic          free_out,
  output logic          claim,
  output logic          used,
  output logic [15:0]   user,
  output logic [CW-1:0] pcnt,
  output logic [CW-1:0] qcnt,
  output logic [HW-1:0] phead,
  output logic [HW-1:0] qhead,
  output logic [31:0]   drops,
  output logic [15:0]   last_pid
);

  logic [CW-1:0] lim;

  // lowest free slot wins: the chain carries "a free slot seen already"
  assign claim    = !used && !free_in;
  assign free_out = free_in || !used;
  assign lim      = CW'(cmd.limit);

  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    if (HW'(QUEUE_DEPTH - 1) == h) return '0;
    return h + HW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (sel && cmd.kind == C_ADD) begin
      user <= cmd.user;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      pcnt     <= '0;
      qcnt     <= '0;
      phead    <= '0;
      qhead    <= '0;
      drops    <= '0;
      last_pid <= NO_SENDER;
    end else if (sel) begin
      case (cmd.kind)
        C_ADD: begin
          used     <= 1'b1;
          pcnt     <= '0;
          qcnt     <= '0;
          phead    <= '0;
          qhead    <= '0;
          drops    <= '0;
          last_pid <= NO_SENDER;
        end
        C_REMOVE: begin
          used <= 1'b0;
          pcnt <= '0;
          qcnt <= '0;
        end
        C_PPUSH: begin
          pcnt     <= pcnt + CW'(1);
          last_pid <= {1'b0, cmd.sender};
        end
        C_QPUSH: qcnt <= qcnt + CW'(1);
        C_PDROP, C_QDROP: begin
          if (drops != '1) drops <= drops + 32'd1;
        end
        C_PPOP: begin
          phead <= head_inc(phead);
          pcnt  <= pcnt - CW'(1);
        end
        C_QPOP: begin
          qhead <= head_inc(qhead);
          qcnt  <= qcnt - CW'(1);
        end
        C_TRIM: begin
          if (pcnt > lim) pcnt <= lim;
          if (qcnt > lim) qcnt <= lim;
        end
        C_CLEAR: begin
          pcnt  <= '0;
          qcnt  <= '0;
          phead <= '0;
          qhead <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/per_user_mailbox_queues_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_user_mailbox_queues_unit
// Mailbox engine: a row of user slot cells, each owning a private and a
// public bounded FIFO kept in two shared RAMs. One request transaction is
// worked at a time. Most operations pass through accept, execute and load
// the response register before the unit is ready again; a read adds a step
// for the registered RAM read, and a public post or a limit decrease walks
// the slot cells one per cycle, since each slot costs one write port
// access or one trim step. The last step waits while a previous response
// transaction is still held by the receiver. The enabled register is
// written in any cycle; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module per_user_mailbox_queues_unit import mbq_pkg::*; #(
  parameter int MAX_USERS    = MAX_USERS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  mbq_req_if.sink   req,
  mbq_rsp_if.source rsp,
  mbq_cfg_if.sink   cfg
);

  localparam int SW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = MAX_USERS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int UW    = $clog2(MAX_USERS + 1);
  localparam int LIM_INIT = (LIMIT_CAP < QUEUE_DEPTH) ? LIMIT_CAP : QUEUE_DEPTH;

  state_t state, state_next;
  logic   enabled;
  logic [CW-1:0] limit, limit_next;
  logic [UW-1:0] user_total, user_total_next;
  logic [TW-1:0] msg_total, msg_total_next;
  logic [SW-1:0] idx, idx_next;
  logic          walk_pub, walk_pub_next;
  logic          rd_pub, rd_pub_next;

  logic [3:0]  r_op;
  logic [15:0] r_uid, r_caller;
  logic [14:0] r_sender;
  logic [PAYLOAD_BITS-1:0] r_word;
  logic [7:0]  r_lim;

  status_t     res_status, res_status_next;
  logic [63:0] res_msg, res_msg_next;
  logic        res_mvalid, res_mvalid_next;
  logic [4:0]  res_fill, res_fill_next;
  logic [31:0] res_drops, res_drops_next;
  logic [15:0] res_last, res_last_next;
  logic [4:0]  res_lim, res_lim_next;
  logic [3:0]  res_users, res_users_next;
  logic [7:0]  res_tot, res_tot_next;

  mbq_cmd_t cmd;
  logic [MAX_USERS-1:0] sel, claim, c_used;
  logic [MAX_USERS:0]   free_chain;
  logic [15:0]   c_user  [MAX_USERS];
  logic [CW-1:0] c_pcnt  [MAX_USERS];
  logic [CW-1:0] c_qcnt  [MAX_USERS];
  logic [HW-1:0] c_phead [MAX_USERS];
  logic [HW-1:0] c_qhead [MAX_USERS];
  logic [31:0]   c_drops [MAX_USERS];
  logic [15:0]   c_last  [MAX_USERS];

  logic          p_we, q_we;
  logic [AW-1:0] waddr, raddr;
  logic [PAYLOAD_BITS-1:0] p_rdata, q_rdata;

  logic u_hit, c_hit;
  logic [SW-1:0] u_slot, sl;
  logic [CW-1:0] s_pcnt, s_qcnt;
  logic [8:0]    nl_wide;
  logic [CW-1:0] nl;

  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_USERS; i++) begin : g_cell
    mbq_cell #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[i]),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .claim    (claim[i]),
      .used     (c_used[i]),
      .user     (c_user[i]),
      .pcnt     (c_pcnt[i]),
      .qcnt     (c_qcnt[i]),
      .phead    (c_phead[i]),
      .qhead    (c_qhead[i]),
      .drops    (c_drops[i]),
      .last_pid (c_last[i])
    );
  end

  mbq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_private_ram (
    .clk (clk), .we (p_we), .waddr (waddr), .wdata (r_word),
    .raddr (raddr), .rdata (p_rdata)
  );

  mbq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_public_ram (
    .clk (clk), .we (q_we), .waddr (waddr), .wdata (r_word),
    .raddr (raddr), .rdata (q_rdata)
  );

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                              input logic [HW-1:0] h,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) sum = sum - (CW+1)'(QUEUE_DEPTH);
    return AW'(AW'(s) * AW'(QUEUE_DEPTH)) + AW'(sum);
  endfunction

  // slot lookups
  always_comb begin
    u_hit  = 1'b0;
    c_hit  = 1'b0;
    u_slot = '0;
    for (int i = 0; i < MAX_USERS; i++) begin
      if (c_used[i] && c_user[i] == r_uid && !u_hit) begin
        u_hit  = 1'b1;
        u_slot = SW'(i);
      end
      if (c_used[i] && c_user[i] == r_caller) c_hit = 1'b1;
    end
  end

  assign sl     = (state == S_WALK) ? idx : u_slot;
  assign s_pcnt = c_pcnt[sl];
  assign s_qcnt = c_qcnt[sl];

  always_comb begin
    nl_wide = {1'b0, r_lim};
    if (nl_wide > 9'(LIMIT_CAP)) nl_wide = 9'(LIMIT_CAP);
    if (nl_wide > 9'(QUEUE_DEPTH)) nl_wide = 9'(QUEUE_DEPTH);
    nl = CW'(nl_wide);
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    limit_next      = limit;
    user_total_next = user_total;
    msg_total_next  = msg_total;
    idx_next        = idx;
    walk_pub_next   = walk_pub;
    rd_pub_next     = rd_pub;
    res_status_next = res_status;
    res_msg_next    = res_msg;
    res_mvalid_next = res_mvalid;
    res_fill_next   = res_fill;
    res_drops_next  = res_drops;
    res_last_next   = res_last;
    res_lim_next    = res_lim;
    res_users_next  = res_users;
    res_tot_next    = res_tot;
    cmd.kind   = C_NONE;
    cmd.user   = r_uid;
    cmd.sender = r_sender;
    cmd.limit  = LIM_W'(limit);
    sel   = '0;
    p_we  = 1'b0;
    q_we  = 1'b0;
    waddr = slot_addr(sl, c_phead[sl], s_pcnt);
    raddr = slot_addr(sl, c_phead[sl], '0);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next      = S_EXEC;
          res_status_next = ST_OK;
          res_msg_next    = '0;
          res_mvalid_next = 1'b0;
          res_fill_next   = '0;
          res_drops_next  = '0;
          res_last_next   = '0;
          res_lim_next    = '0;
          res_users_next  = '0;
          res_tot_next    = '0;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        if (!enabled && (r_op == OP_POST_PRIV || r_op == OP_POST_PUB ||
                         r_op == OP_READ_PRIV || r_op == OP_READ_PUB)) begin
          res_status_next = ST_STOPPED;
        end else begin
          unique case (op_t'(r_op))
            OP_ADD: begin
              if (u_hit) begin
                res_status_next = ST_EXISTS;
              end else if (!free_chain[MAX_USERS]) begin
                res_status_next = ST_FULL;
              end else begin
                cmd.kind        = C_ADD;
                sel             = claim;
                user_total_next = user_total + UW'(1);
              end
            end
            OP_REMOVE: begin
              if (!u_hit) begin
                res_status_next = ST_NOUSER;
              end else begin
                cmd.kind         = C_REMOVE;
                sel[u_slot]      = 1'b1;
                msg_total_next  = msg_total - TW'(s_pcnt);
                user_total_next = user_total - UW'(1);
              end
            end
            OP_POST_PRIV: begin
              if (!c_hit || !u_hit) begin
                res_status_next = ST_NOUSER;
              end else if (s_pcnt >= limit) begin
                cmd.kind        = C_PDROP;
                sel[u_slot]     = 1'b1;
                res_status_next = ST_NOSPACE;
              end else begin
                cmd.kind       = C_PPUSH;
                sel[u_slot]    = 1'b1;
                p_we           = 1'b1;
                msg_total_next = msg_total + TW'(1);
              end
            end
            OP_POST_PUB: begin
              if (!c_hit) begin
                res_status_next = ST_NOUSER;
              end else begin
                walk_pub_next = 1'b1;
                idx_next      = '0;
                state_next    = S_WALK;
              end
            end
            OP_READ_PRIV, OP_READ_PUB: begin
              rd_pub_next = (r_op == OP_READ_PUB);
              if (!u_hit) begin
                res_status_next = ST_NOUSER;
              end else if (r_op == OP_READ_PUB) begin
                if (s_qcnt == '0) begin
                  res_status_next = ST_EMPTY;
                end else begin
                  raddr       = slot_addr(sl, c_qhead[sl], '0);
                  cmd.kind    = C_QPOP;
                  sel[u_slot] = 1'b1;
                  state_next  = S_READ;
                end
              end else begin
                if (s_pcnt == '0) begin
                  res_status_next = ST_EMPTY;
                end else begin
                  cmd.kind       = C_PPOP;
                  sel[u_slot]    = 1'b1;
                  msg_total_next = msg_total - TW'(1);
                  state_next     = S_READ;
                end
              end
            end
            OP_SET_LIMIT: begin
              limit_next = nl;
              if (nl < limit) begin
                walk_pub_next = 1'b0;
                idx_next      = '0;
                state_next    = S_WALK;
              end
            end
            OP_CLEAR: begin
              cmd.kind       = C_CLEAR;
              sel            = '1;
              msg_total_next = '0;
            end
            OP_QUERY: begin
              if (!u_hit) begin
                res_status_next = ST_NOUSER;
              end else begin
                res_fill_next  = 5'(s_pcnt);
                res_drops_next = c_drops[u_slot];
                res_last_next  = c_last[u_slot];
              end
            end
            OP_TOTALS: begin
              res_lim_next   = 5'(limit);
              res_users_next = 4'(user_total);
              res_tot_next   = 8'(msg_total);
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (c_used[idx]) begin
          sel[idx] = 1'b1;
          if (walk_pub) begin
            if (s_qcnt >= limit) begin
              cmd.kind = C_QDROP;
            end else begin
              cmd.kind = C_QPUSH;
              waddr    = slot_addr(idx, c_qhead[idx], s_qcnt);
              q_we     = 1'b1;
            end
          end else begin
            cmd.kind = C_TRIM;
            if (s_pcnt > limit) msg_total_next = msg_total - TW'(s_pcnt - limit);
          end
        end
        if (idx == SW'(MAX_USERS - 1)) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + SW'(1);
        end
      end

      S_READ: begin
        res_mvalid_next = 1'b1;
        res_msg_next    = rd_pub ? 64'(q_rdata) : 64'(p_rdata);
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      limit      <= CW'(LIM_INIT);
      user_total <= '0;
      msg_total  <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg.valid) enabled <= cfg.enabled;
      limit      <= limit_next;
      user_total <= user_total_next;
      msg_total  <= msg_total_next;
      if (state == S_DONE && !rsp.valid) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready && !(state == S_DONE)) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    walk_pub   <= walk_pub_next;
    rd_pub     <= rd_pub_next;
    res_status <= res_status_next;
    res_msg    <= res_msg_next;
    res_mvalid <= res_mvalid_next;
    res_fill   <= res_fill_next;
    res_drops  <= res_drops_next;
    res_last   <= res_last_next;
    res_lim    <= res_lim_next;
    res_users  <= res_users_next;
    res_tot    <= res_tot_next;
    if (state == S_IDLE && req.valid) begin
      r_op     <= req.operation;
      r_uid    <= req.user_id;
      r_caller <= req.caller_id;
      r_sender <= req.sender_id;
      r_word   <= PAYLOAD_BITS'(req.message_word);
      r_lim    <= req.new_limit;
    end
    // response register loads when the previous transaction has left
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status        <= res_status;
      rsp.message_out   <= res_msg;
      rsp.message_valid <= res_mvalid;
      rsp.private_fill  <= res_fill;
      rsp.drops         <= res_drops;
      rsp.last_sender   <= res_last;
      rsp.limit_now     <= res_lim;
      rsp.users_now     <= res_users;
      rsp.private_total <= res_tot;
    end
  end

  a_user_total: assert property (@(posedge clk) disable iff (rst)
    user_total == UW'($countones(c_used)))
    else $error("user total out of step with used slots");

  a_sel_single: assert property (@(posedge clk) disable iff (rst)
    (cmd.kind != C_CLEAR && cmd.kind != C_ADD) |-> $onehot0(sel))
    else $error("more than one slot cell selected");

  a_msg_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.message_valid) |-> (rsp.status == ST_OK))
    else $error("popped message with error status");

  a_msg_bound: assert property (@(posedge clk) disable iff (rst)
    msg_total <= TW'(DEPTH))
    else $error("private message total overflow");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Mailbox unit bench: a behavioral mailbox tracks users, queues, drop counts
// and totals, predicts each response and checks it field by field, under
// random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
import mbq_pkg::*;

typedef struct packed {
  status_t     status;
  logic [63:0] message_out;
  logic        message_valid;
  logic [4:0]  private_fill;
  logic [31:0] drops;
  logic [15:0] last_sender;
  logic [4:0]  limit_now;
  logic [3:0]  users_now;
  logic [7:0]  private_total;
} mbox_rsp_t;

class mailbox_scoreboard;
  bit          enabled;
  bit          used [8];
  logic [15:0] uid_of [8];
  logic [63:0] priv_q [8][$];
  logic [63:0] pub_q [8][$];
  logic [31:0] drop_cnt [8];
  logic [15:0] last_pid [8];
  int          limit;
  int          n_users;
  int          n_msgs;
  mbox_rsp_t   pending [$];
  int          errors;
  int          n_checked;

  function void clear_state();
    enabled = 1;
    for (int s = 0; s < 8; s++) begin
      used[s] = 0; uid_of[s] = 0; priv_q[s] = {}; pub_q[s] = {};
      drop_cnt[s] = 0; last_pid[s] = NO_SENDER;
    end
    limit = LIMIT_CAP; n_users = 0; n_msgs = 0;
    pending = {}; errors = 0; n_checked = 0;
  endfunction

  function int slot_of(logic [15:0] id);
    for (int s = 0; s < 8; s++)
      if (used[s] && uid_of[s] == id) return s;
    return -1;
  endfunction

  function void bump_drop(int s);
    if (drop_cnt[s] != 32'hFFFF_FFFF) drop_cnt[s]++;
  endfunction

  function void note_request(logic [3:0] op, logic [15:0] uid, logic [15:0] caller,
                             logic [14:0] sender, logic [63:0] word, logic [7:0] nl);
    mbox_rsp_t r;
    int s;
    int lim;
    r = '0;
    r.status = ST_OK;
    if (!enabled && op >= OP_POST_PRIV && op <= OP_READ_PUB) r.status = ST_STOPPED;
    else case (op)
      OP_ADD: begin
        if (slot_of(uid) >= 0) r.status = ST_EXISTS;
        else begin
          for (s = 0; s < 8 && used[s]; s++) ;
          if (s >= 8) r.status = ST_FULL;
          else begin
            used[s] = 1; uid_of[s] = uid; priv_q[s] = {}; pub_q[s] = {};
            drop_cnt[s] = 0; last_pid[s] = NO_SENDER; n_users++;
          end
        end
      end
      OP_REMOVE: begin
        s = slot_of(uid);
        if (s < 0) r.status = ST_NOUSER;
        else begin
          n_msgs -= priv_q[s].size();
          used[s] = 0; priv_q[s] = {}; pub_q[s] = {}; n_users--;
        end
      end
      OP_POST_PRIV: begin
        s = slot_of(uid);
        if (slot_of(caller) < 0 || s < 0) r.status = ST_NOUSER;
        else if (priv_q[s].size() >= limit) begin
          bump_drop(s); r.status = ST_NOSPACE;
        end else begin
          priv_q[s].push_back(word); last_pid[s] = {1'b0, sender}; n_msgs++;
        end
      end
      OP_POST_PUB: begin
        if (slot_of(caller) < 0) r.status = ST_NOUSER;
        else for (s = 0; s < 8; s++) begin
          if (!used[s]) continue;
          if (pub_q[s].size() >= limit) bump_drop(s);
          else pub_q[s].push_back(word);
        end
      end
      OP_READ_PRIV, OP_READ_PUB: begin
        s = slot_of(uid);
        if (s < 0) r.status = ST_NOUSER;
        else if (op == OP_READ_PRIV) begin
          if (priv_q[s].size() == 0) r.status = ST_EMPTY;
          else begin
            r.message_out = priv_q[s].pop_front(); r.message_valid = 1; n_msgs--;
          end
        end else begin
          if (pub_q[s].size() == 0) r.status = ST_EMPTY;
          else begin
            r.message_out = pub_q[s].pop_front(); r.message_valid = 1;
          end
        end
      end
      OP_SET_LIMIT: begin
        lim = (nl > LIMIT_CAP) ? LIMIT_CAP : nl;
        if (lim < limit)
          for (s = 0; s < 8; s++) begin
            if (!used[s]) continue;
            while (priv_q[s].size() > lim) begin
              void'(priv_q[s].pop_back()); n_msgs--;
            end
            while (pub_q[s].size() > lim) void'(pub_q[s].pop_back());
          end
        limit = lim;
      end
      OP_CLEAR: begin
        for (s = 0; s < 8; s++) begin
          priv_q[s] = {}; pub_q[s] = {};
        end
        n_msgs = 0;
      end
      OP_QUERY: begin
        s = slot_of(uid);
        if (s < 0) r.status = ST_NOUSER;
        else begin
          r.private_fill = 5'(priv_q[s].size()); r.drops = drop_cnt[s];
          r.last_sender = last_pid[s];
        end
      end
      OP_TOTALS: begin
        r.limit_now = 5'(limit); r.users_now = 4'(n_users);
        r.private_total = 8'(n_msgs);
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_response(mbox_rsp_t a);
    mbox_rsp_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response status %0d", a.status);
      return;
    end
    e = pending.pop_front();
    n_checked++;
    if (a !== e) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp st=%0d msg=%h v=%0d fill=%0d dr=%0d ls=%h lim=%0d u=%0d tot=%0d",
                 e.status, e.message_out, e.message_valid, e.private_fill, e.drops,
                 e.last_sender, e.limit_now, e.users_now, e.private_total);
      if (errors <= 10)
        $display("         act st=%0d msg=%h v=%0d fill=%0d dr=%0d ls=%h lim=%0d u=%0d tot=%0d",
                 a.status, a.message_out, a.message_valid, a.private_fill, a.drops,
                 a.last_sender, a.limit_now, a.users_now, a.private_total);
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;

  mbq_req_if req ();
  mbq_rsp_if rsp ();
  mbq_cfg_if cfg ();

  per_user_mailbox_queues_unit u_dut (
    .clk (clk), .rst (rst), .req (req.sink), .rsp (rsp.source), .cfg (cfg.sink)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  mailbox_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  int  cycle_count;
  int  n_sent;
  logic [15:0] known_ids [6] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00A5, 16'h7F00};

  initial begin
    req.valid = 0; req.operation = 0; req.user_id = 0; req.caller_id = 0;
    req.sender_id = 0; req.message_word = 0; req.new_limit = 0;
    rsp.ready = 0; cfg.valid = 0; cfg.enabled = 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // response side: random stalls, with an optional long hold-off
  always @(posedge clk) begin
    mbox_rsp_t a;
    if (!rst && rsp.valid && rsp.ready) begin
      a.status = status_t'(rsp.status); a.message_out = rsp.message_out;
      a.message_valid = rsp.message_valid; a.private_fill = rsp.private_fill;
      a.drops = rsp.drops; a.last_sender = rsp.last_sender;
      a.limit_now = rsp.limit_now; a.users_now = rsp.users_now;
      a.private_total = rsp.private_total;
      sb.check_response(a);
    end
    if (rst) rsp.ready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 0;
    end else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high after an accept; it drops only for idle gaps and pauses
  task automatic send(logic [3:0] op, logic [15:0] uid, logic [15:0] caller,
                      logic [14:0] sender, logic [63:0] word, logic [7:0] nl);
    bit idle;
    idle = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
    if (idle) req.valid <= 0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    req.valid <= 1; req.operation <= op; req.user_id <= uid; req.caller_id <= caller;
    req.sender_id <= sender; req.message_word <= word; req.new_limit <= nl;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, uid, caller, sender, word, nl);
    n_sent++;
  endtask

  task automatic write_enable(bit en);
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg.valid <= 1; cfg.enabled <= en;
    do @(posedge clk); while (!cfg.ready);
    sb.enabled = en;
    cfg.valid <= 0;
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(9) == 0) ? 16'($urandom) : known_ids[$urandom_range(5)];
  endfunction

  task automatic random_item();
    int k;
    logic [3:0] op;
    k = $urandom_range(99);
    if (k < 8) op = OP_ADD;
    else if (k < 12) op = OP_REMOVE;
    else if (k < 40) op = OP_POST_PRIV;
    else if (k < 52) op = OP_POST_PUB;
    else if (k < 70) op = OP_READ_PRIV;
    else if (k < 80) op = OP_READ_PUB;
    else if (k < 84) op = OP_SET_LIMIT;
    else if (k < 85) op = OP_CLEAR;
    else if (k < 92) op = OP_QUERY;
    else if (k < 97) op = OP_TOTALS;
    else op = 4'($urandom_range(15));
    send(op, pick_id(), pick_id(), 15'($urandom), {$urandom, $urandom},
         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(17)));
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (count) random_item();
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    cycle_count = 0; n_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, every operation, the corner cases
    send(OP_READ_PRIV, 16'h0000, 0, 0, 0, 0);                  // no user
    send(OP_ADD, 16'h0000, 0, 0, 0, 0);
    send(OP_ADD, 16'hFFFF, 0, 0, 0, 0);
    send(OP_ADD, 16'hFFFF, 0, 0, 0, 0);                        // user exists
    send(OP_POST_PRIV, 16'hFFFF, 16'h4444, 0, 64'h1, 0);        // bad caller
    send(OP_POST_PRIV, 16'hFFFF, 16'h0000, 15'h7FFF, '1, 0);
    send(OP_POST_PUB, 0, 16'hFFFF, 0, 64'h8000_0000_0000_0001, 0);
    send(OP_QUERY, 16'hFFFF, 0, 0, 0, 0);
    send(OP_QUERY, 16'h0000, 0, 0, 0, 0);                      // no sender yet
    send(OP_READ_PRIV, 16'hFFFF, 0, 0, 0, 0);
    send(OP_READ_PRIV, 16'hFFFF, 0, 0, 0, 0);                  // empty
    send(OP_READ_PUB, 16'h0000, 0, 0, 0, 0);
    send(OP_SET_LIMIT, 0, 0, 0, 0, 8'hFF);                     // clamps
    send(OP_SET_LIMIT, 0, 0, 0, 0, 8'd0);
    send(OP_POST_PRIV, 16'h0000, 16'h0000, 15'd5, 64'h55, 0);   // no space
    send(OP_POST_PUB, 0, 16'h0000, 0, 64'h66, 0);               // drops on all
    send(OP_SET_LIMIT, 0, 0, 0, 0, 8'd16);
    for (int i = 0; i < 8; i++) send(OP_ADD, 16'(i + 16'h0100), 0, 0, 0, 0); // fills
    send(OP_TOTALS, 0, 0, 0, 0, 0);
    send(4'd15, 0, 0, 0, 0, 0);                                // unknown
    send(OP_CLEAR, 0, 0, 0, 0, 0);
    send(OP_REMOVE, 16'h0100, 0, 0, 0, 0);
    send(OP_REMOVE, 16'h0100, 0, 0, 0, 0);
    write_enable(0);
    send(OP_POST_PRIV, 16'h0000, 16'h0000, 0, 0, 0);
    send(OP_READ_PUB, 16'h0000, 0, 0, 0, 0);
    send(OP_QUERY, 16'h0000, 0, 0, 0, 0);
    write_enable(1);
    for (int i = 0; i < 8; i++) send(OP_REMOVE, 16'(i + 16'h0100), 0, 0, 0, 0);

    run_phase(0, 0, 250);
    run_phase(76, 0, 200);
    // long hold-off on responses while requests keep coming
    hold_cycles = 400;
    run_phase(0, 76, 250);
    write_enable(0);
    run_phase(0, 0, 60);
    write_enable(1);
    run_phase(19, 19, 200);
    run_phase(0, 0, 150);
    req.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("run covered %0d requests, %0d responses checked, enable toggled both ways",
             n_sent, sb.n_checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// File: files.f
rtl/mbq_pkg.sv
rtl/mbq_if.sv
rtl/mbq_ram.sv
rtl/mbq_cell.sv
rtl/per_user_mailbox_queues_unit.sv
bench/tb_top.sv
